// ===== rtl/nrdf_pkg.sv =====
package nrdf_pkg;

  localparam int OFFSET_BITS = 14;
  localparam int WD_W = OFFSET_BITS + 1;
  localparam int CFG_W = OFFSET_BITS;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(7168);

  localparam logic [0:0] REG_DAY_OFFSET = 1'd0;
  localparam logic [0:0] REG_ENABLE = 1'd1;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_DINIT, ST_YEAR, ST_MONTH, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_START, PH_PASS, PH_RMC, PH_TAIL} phase_t;

  typedef enum logic [2:0] {
    PL_FLUSH, PL_HEAD, PL_BYTE, PL_BYTE_X, PL_COMMA, PL_TRAILER, PL_DATE
  } plan_t;

  typedef enum logic [2:0] {
    SEL_BYTE, SEL_LEAD, SEL_COMMA, SEL_STAR, SEL_HEXH, SEL_HEXL, SEL_NL, SEL_DATE
  } sel_t;

  typedef struct packed {
    logic       byte_load;
    logic       digit_wr;
    logic [2:0] idx;
    logic [2:0] cif;
    logic       d_init;
    logic       year_step;
    logic       month_step;
    logic       emit;
    sel_t       sel;
    logic       xor_en;
    logic       xor_clr;
    logic       line_end;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic is_nl;
    logic is_cr;
    logic is_star;
    logic is_comma;
    logic lead_match;
    logic slot_free;
    logic year_more;
    logic month_more;
  } sts_t;

  function automatic logic [7:0] lead_char(input logic [2:0] i);
    case (i)
      3'd0: lead_char = 8'h24;
      3'd1: lead_char = 8'h47;
      3'd2: lead_char = 8'h50;
      3'd3: lead_char = 8'h52;
      3'd4: lead_char = 8'h4D;
      3'd5: lead_char = 8'h43;
      default: lead_char = 8'h00;
    endcase
  endfunction

  function automatic logic [8:0] before_month(input logic [6:0] m);
    case (m)
      7'd2: before_month = 9'd31;
      7'd3: before_month = 9'd59;
      7'd4: before_month = 9'd90;
      7'd5: before_month = 9'd120;
      7'd6: before_month = 9'd151;
      7'd7: before_month = 9'd181;
      7'd8: before_month = 9'd212;
      7'd9: before_month = 9'd243;
      7'd10: before_month = 9'd273;
      7'd11: before_month = 9'd304;
      7'd12: before_month = 9'd334;
      default: before_month = 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2: month_len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    div10 = p[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] t;
    t = 7'(div10(v)) * 7'd10;
    mod10 = 4'(v - t);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + 8'(v)) : (8'h37 + 8'(v));
  endfunction

endpackage

// ===== rtl/nrdf_dp.sv =====
module nrdf_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nrdf_pkg::cmd_t                   cmd,
  output nrdf_pkg::sts_t                   sts,
  input  logic [7:0]                       in_byte,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [nrdf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [7:0]                       out_byte,
  output logic                             out_line_end
);

  logic [nrdf_pkg::OFFSET_BITS-1:0] offset_r;
  logic                             enable_r;
  logic [7:0]                       byte_r;
  logic [3:0]                       dig_r [6];
  logic [7:0]                       xor_r, xor_nxt;
  logic [nrdf_pkg::WD_W-1:0]        wd_r, wd_nxt;
  logic [6:0]                       yy_r, yy_nxt;
  logic [1:0]                       cent_r, cent_nxt;
  logic [3:0]                       mon_r, mon_nxt;
  logic                             ov_r;
  logic [7:0]                       ob_r;
  logic                             oe_r;

  logic [3:0] dg [6];
  logic [6:0] d_v, m_v, y_v;
  logic       leap, leap0;
  logic [8:0] ylen;
  logic [5:0] mlen;
  logic [8:0] t_v;
  logic [7:0] emit_byte;
  logic [6:0] wd7;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dg[i] = (3'(i) < cmd.cif) ? dig_r[i] : 4'd0;
    end
    d_v = 7'(dg[0]) * 7'd10 + 7'(dg[1]);
    m_v = 7'(dg[2]) * 7'd10 + 7'(dg[3]);
    y_v = 7'(dg[4]) * 7'd10 + 7'(dg[5]);
    leap0 = (y_v == 7'd0) || ((y_v[1:0] == 2'd0) && (y_v != 7'd99));
    t_v = 9'(d_v) + nrdf_pkg::before_month(m_v) + 9'(leap0 && (m_v > 7'd2));
    leap = (yy_r == 7'd0) ? (cent_r == 2'd0) : (yy_r[1:0] == 2'd0);
    ylen = leap ? 9'd366 : 9'd365;
    mlen = 6'(nrdf_pkg::month_len(mon_r)) + 6'(leap && (mon_r == 4'd2));
  end

  always_comb begin
    wd_nxt = wd_r;
    yy_nxt = yy_r;
    cent_nxt = cent_r;
    mon_nxt = mon_r;
    if (cmd.d_init) begin
      wd_nxt = nrdf_pkg::WD_W'(t_v) + nrdf_pkg::WD_W'(offset_r);
      yy_nxt = y_v;
      cent_nxt = (y_v == 7'd99) ? 2'd3 : 2'd0;
      mon_nxt = 4'd1;
    end else if (cmd.year_step) begin
      wd_nxt = wd_r - nrdf_pkg::WD_W'(ylen);
      if (yy_r == 7'd99) begin
        yy_nxt = 7'd0;
        cent_nxt = cent_r + 2'd1;
      end else begin
        yy_nxt = yy_r + 7'd1;
      end
    end else if (cmd.month_step) begin
      wd_nxt = wd_r - nrdf_pkg::WD_W'(mlen);
      mon_nxt = mon_r + 4'd1;
    end
  end

  assign wd7 = wd_r[6:0];

  always_comb begin
    case (cmd.sel)
      nrdf_pkg::SEL_BYTE:  emit_byte = byte_r;
      nrdf_pkg::SEL_LEAD:  emit_byte = nrdf_pkg::lead_char(cmd.idx);
      nrdf_pkg::SEL_COMMA: emit_byte = nrdf_pkg::CH_COMMA;
      nrdf_pkg::SEL_STAR:  emit_byte = nrdf_pkg::CH_STAR;
      nrdf_pkg::SEL_HEXH:  emit_byte = nrdf_pkg::hex_char(xor_r[7:4]);
      nrdf_pkg::SEL_HEXL:  emit_byte = nrdf_pkg::hex_char(xor_r[3:0]);
      nrdf_pkg::SEL_NL:    emit_byte = nrdf_pkg::CH_NL;
      nrdf_pkg::SEL_DATE: begin
        case (cmd.idx)
          3'd0: emit_byte = nrdf_pkg::CH_ZERO + 8'(nrdf_pkg::div10(wd7));
          3'd1: emit_byte = nrdf_pkg::CH_ZERO + 8'(nrdf_pkg::mod10(wd7));
          3'd2: emit_byte = nrdf_pkg::CH_ZERO + 8'(nrdf_pkg::div10(7'(mon_r)));
          3'd3: emit_byte = nrdf_pkg::CH_ZERO + 8'(nrdf_pkg::mod10(7'(mon_r)));
          3'd4: emit_byte = nrdf_pkg::CH_ZERO + 8'(nrdf_pkg::div10(yy_r));
          default: emit_byte = nrdf_pkg::CH_ZERO + 8'(nrdf_pkg::mod10(yy_r));
        endcase
      end
      default: emit_byte = byte_r;
    endcase
  end

  always_comb begin
    xor_nxt = xor_r;
    if (cmd.emit && cmd.xor_clr) begin
      xor_nxt = 8'd0;
    end else if (cmd.emit && cmd.xor_en) begin
      xor_nxt = xor_r ^ emit_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= nrdf_pkg::OFFSET_RESET;
      enable_r <= 1'b1;
      xor_r <= 8'd0;
      wd_r <= '0;
      yy_r <= 7'd0;
      cent_r <= 2'd0;
      mon_r <= 4'd1;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == nrdf_pkg::REG_DAY_OFFSET)) begin
        offset_r <= cfg_data[nrdf_pkg::OFFSET_BITS-1:0];
      end
      if (cfg_we && (cfg_index == nrdf_pkg::REG_ENABLE)) begin
        enable_r <= cfg_data[0];
      end
      xor_r <= xor_nxt;
      wd_r <= wd_nxt;
      yy_r <= yy_nxt;
      cent_r <= cent_nxt;
      mon_r <= mon_nxt;
      if (cmd.emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_load) begin
      byte_r <= in_byte;
    end
    if (cmd.digit_wr) begin
      dig_r[cmd.cif] <= ((byte_r >= 8'h30) && (byte_r <= 8'h39)) ? byte_r[3:0] : 4'd0;
    end
    if (cmd.emit) begin
      ob_r <= emit_byte;
      oe_r <= cmd.line_end;
    end
  end

  assign sts.enable = enable_r;
  assign sts.is_nl = (byte_r == nrdf_pkg::CH_NL);
  assign sts.is_cr = (byte_r == nrdf_pkg::CH_CR);
  assign sts.is_star = (byte_r == nrdf_pkg::CH_STAR);
  assign sts.is_comma = (byte_r == nrdf_pkg::CH_COMMA);
  assign sts.lead_match = (byte_r == nrdf_pkg::lead_char(cmd.idx));
  assign sts.slot_free = !ov_r || out_ready;
  assign sts.year_more = (wd_r > nrdf_pkg::WD_W'(ylen));
  assign sts.month_more = (mon_r < 4'd12) && (wd_r > nrdf_pkg::WD_W'(mlen));

  assign out_valid = ov_r;
  assign out_byte = ob_r;
  assign out_line_end = oe_r;

endmodule

// ===== rtl/nrdf_ctrl.sv =====
module nrdf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  nrdf_pkg::sts_t sts,
  output nrdf_pkg::cmd_t cmd
);

  nrdf_pkg::state_t state_r, state_nxt;
  nrdf_pkg::phase_t phase_r, phase_nxt;
  nrdf_pkg::plan_t  plan_r, plan_nxt;
  logic [2:0] pfx_r, pfx_nxt;
  logic [3:0] field_r, field_nxt;
  logic [2:0] cif_r, cif_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] last_r, last_nxt;
  logic       delim_r, delim_nxt;
  logic       comma_r, comma_nxt;

  logic            dec_emit, dec_date, dec_wr;
  nrdf_pkg::plan_t dec_plan;
  logic [2:0]      dec_last;
  logic            cnt_done;

  assign cnt_done = (cnt_r == last_r);

  // per-request decision
  always_comb begin
    dec_emit = 1'b0;
    dec_date = 1'b0;
    dec_wr = 1'b0;
    dec_plan = nrdf_pkg::PL_BYTE;
    dec_last = 3'd0;
    case (phase_r)
      nrdf_pkg::PH_START: begin
        if (sts.enable && sts.lead_match) begin
          if (pfx_r == 3'd5) begin
            dec_emit = 1'b1;
            dec_plan = nrdf_pkg::PL_HEAD;
            dec_last = 3'd5;
          end
        end else begin
          dec_emit = 1'b1;
          dec_plan = nrdf_pkg::PL_FLUSH;
          dec_last = pfx_r;
        end
      end
      nrdf_pkg::PH_PASS: begin
        dec_emit = 1'b1;
      end
      default: begin
        if (sts.is_nl) begin
          dec_emit = 1'b1;
          dec_plan = nrdf_pkg::PL_TRAILER;
          dec_last = 3'd3;
        end else if ((phase_r == nrdf_pkg::PH_TAIL) || sts.is_cr) begin
          dec_emit = 1'b0;
        end else if (sts.is_star || sts.is_comma) begin
          if ((field_r == 4'd9) && (cif_r inside {[3'd1:3'd5]})) begin
            dec_date = 1'b1;
          end else if (sts.is_comma && (field_r <= 4'd11)) begin
            dec_emit = 1'b1;
            dec_plan = nrdf_pkg::PL_COMMA;
          end
        end else if (field_r <= 4'd8) begin
          dec_emit = 1'b1;
          dec_plan = nrdf_pkg::PL_BYTE_X;
        end else if (field_r == 4'd9) begin
          if (cif_r < 3'd6) begin
            dec_wr = 1'b1;
            dec_date = (cif_r == 3'd5);
          end
        end else if ((field_r == 4'd12) && (cif_r == 3'd0)) begin
          dec_emit = 1'b1;
          dec_plan = nrdf_pkg::PL_BYTE_X;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nrdf_pkg::ST_IDLE: if (in_valid) state_nxt = nrdf_pkg::ST_DECIDE;
      nrdf_pkg::ST_DECIDE: begin
        if (dec_date) state_nxt = nrdf_pkg::ST_DINIT;
        else if (dec_emit) state_nxt = nrdf_pkg::ST_EMIT;
        else state_nxt = nrdf_pkg::ST_IDLE;
      end
      nrdf_pkg::ST_DINIT: state_nxt = nrdf_pkg::ST_YEAR;
      nrdf_pkg::ST_YEAR: if (!sts.year_more) state_nxt = nrdf_pkg::ST_MONTH;
      nrdf_pkg::ST_MONTH: if (!sts.month_more) state_nxt = nrdf_pkg::ST_EMIT;
      nrdf_pkg::ST_EMIT: if (sts.slot_free && cnt_done) state_nxt = nrdf_pkg::ST_IDLE;
      default: state_nxt = nrdf_pkg::ST_IDLE;
    endcase
  end

  // line tracking
  always_comb begin
    phase_nxt = phase_r;
    plan_nxt = plan_r;
    pfx_nxt = pfx_r;
    field_nxt = field_r;
    cif_nxt = cif_r;
    cnt_nxt = cnt_r;
    last_nxt = last_r;
    delim_nxt = delim_r;
    comma_nxt = comma_r;
    case (state_r)
      nrdf_pkg::ST_DECIDE: begin
        cnt_nxt = 3'd0;
        plan_nxt = dec_plan;
        last_nxt = dec_last;
        if (dec_date) begin
          plan_nxt = nrdf_pkg::PL_DATE;
          delim_nxt = sts.is_star || sts.is_comma;
          comma_nxt = sts.is_comma;
          last_nxt = sts.is_comma ? 3'd6 : 3'd5;
        end
        case (phase_r)
          nrdf_pkg::PH_START: begin
            if (sts.enable && sts.lead_match) begin
              if (pfx_r == 3'd5) begin
                phase_nxt = nrdf_pkg::PH_RMC;
                pfx_nxt = 3'd0;
                field_nxt = 4'd0;
                cif_nxt = 3'd0;
              end else begin
                pfx_nxt = pfx_r + 3'd1;
              end
            end else begin
              pfx_nxt = 3'd0;
              phase_nxt = sts.is_nl ? nrdf_pkg::PH_START : nrdf_pkg::PH_PASS;
            end
          end
          nrdf_pkg::PH_PASS: begin
            if (sts.is_nl) begin
              phase_nxt = nrdf_pkg::PH_START;
              pfx_nxt = 3'd0;
              field_nxt = 4'd0;
              cif_nxt = 3'd0;
            end
          end
          default: begin
            if (sts.is_nl) begin
              phase_nxt = nrdf_pkg::PH_START;
              pfx_nxt = 3'd0;
              field_nxt = 4'd0;
              cif_nxt = 3'd0;
            end else if ((phase_r == nrdf_pkg::PH_TAIL) || sts.is_cr) begin
              phase_nxt = phase_r;
            end else if (sts.is_star || sts.is_comma) begin
              if (!dec_date) begin
                if (sts.is_star) begin
                  phase_nxt = nrdf_pkg::PH_TAIL;
                end else begin
                  if (field_r <= 4'd12) field_nxt = field_r + 4'd1;
                  cif_nxt = 3'd0;
                end
              end
            end else if ((field_r == 4'd9) && (cif_r < 3'd6)) begin
              cif_nxt = cif_r + 3'd1;
            end else if ((field_r == 4'd12) && (cif_r == 3'd0)) begin
              cif_nxt = 3'd1;
            end
          end
        endcase
      end
      nrdf_pkg::ST_DINIT: begin
        if (delim_r) begin
          if (comma_r) begin
            field_nxt = field_r + 4'd1;
            cif_nxt = 3'd0;
          end else begin
            phase_nxt = nrdf_pkg::PH_TAIL;
          end
        end
      end
      nrdf_pkg::ST_EMIT: begin
        if (sts.slot_free) cnt_nxt = cnt_r + 3'd1;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sel = nrdf_pkg::SEL_BYTE;
    cmd.cif = cif_r;
    cmd.idx = (state_r == nrdf_pkg::ST_EMIT) ? cnt_r : pfx_r;
    cmd.byte_load = (state_r == nrdf_pkg::ST_IDLE) && in_valid;
    cmd.digit_wr = (state_r == nrdf_pkg::ST_DECIDE) && dec_wr;
    cmd.d_init = (state_r == nrdf_pkg::ST_DINIT);
    cmd.year_step = (state_r == nrdf_pkg::ST_YEAR) && sts.year_more;
    cmd.month_step = (state_r == nrdf_pkg::ST_MONTH) && sts.month_more;
    cmd.emit = (state_r == nrdf_pkg::ST_EMIT) && sts.slot_free;
    case (plan_r)
      nrdf_pkg::PL_FLUSH: begin
        cmd.sel = cnt_done ? nrdf_pkg::SEL_BYTE : nrdf_pkg::SEL_LEAD;
        cmd.line_end = cnt_done && sts.is_nl;
      end
      nrdf_pkg::PL_HEAD: begin
        cmd.sel = nrdf_pkg::SEL_LEAD;
        cmd.xor_clr = (cnt_r == 3'd0);
        cmd.xor_en = (cnt_r != 3'd0);
      end
      nrdf_pkg::PL_BYTE: begin
        cmd.line_end = sts.is_nl;
      end
      nrdf_pkg::PL_BYTE_X: begin
        cmd.xor_en = 1'b1;
      end
      nrdf_pkg::PL_COMMA: begin
        cmd.sel = nrdf_pkg::SEL_COMMA;
        cmd.xor_en = 1'b1;
      end
      nrdf_pkg::PL_TRAILER: begin
        case (cnt_r)
          3'd0: cmd.sel = nrdf_pkg::SEL_STAR;
          3'd1: cmd.sel = nrdf_pkg::SEL_HEXH;
          3'd2: cmd.sel = nrdf_pkg::SEL_HEXL;
          default: begin
            cmd.sel = nrdf_pkg::SEL_NL;
            cmd.line_end = 1'b1;
            cmd.xor_clr = 1'b1;
          end
        endcase
      end
      nrdf_pkg::PL_DATE: begin
        cmd.sel = (cnt_r == 3'd6) ? nrdf_pkg::SEL_COMMA : nrdf_pkg::SEL_DATE;
        cmd.xor_en = 1'b1;
      end
      default: cmd.sel = nrdf_pkg::SEL_BYTE;
    endcase
  end

  assign in_ready = (state_r == nrdf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nrdf_pkg::ST_IDLE;
      phase_r <= nrdf_pkg::PH_START;
      plan_r <= nrdf_pkg::PL_BYTE;
      pfx_r <= 3'd0;
      field_r <= 4'd0;
      cif_r <= 3'd0;
      cnt_r <= 3'd0;
      last_r <= 3'd0;
      delim_r <= 1'b0;
      comma_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      plan_r <= plan_nxt;
      pfx_r <= pfx_nxt;
      field_r <= field_nxt;
      cif_r <= cif_nxt;
      cnt_r <= cnt_nxt;
      last_r <= last_nxt;
      delim_r <= delim_nxt;
      comma_r <= comma_nxt;
    end
  end

endmodule

// ===== rtl/nmea_rmc_date_rollover_fix.sv =====
// Each request is one input byte. The bytes that a request produces are emitted one
// after another while out_ready is high; a full output register with out_ready low stalls them.
// A date rewrite first walks the day count year by year, then month by month.
// One request at a time: in_ready stays low until the current request is finished.
// Reset (rst_n low, synchronous): line state cleared, day_offset 7168, enable 1.
module nmea_rmc_date_rollover_fix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_line_end,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [nrdf_pkg::CFG_W-1:0] cfg_data
);

  nrdf_pkg::cmd_t cmd;
  nrdf_pkg::sts_t sts;

  nrdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrdf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (in_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .out_line_end (out_line_end)
  );

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_line_end;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = nrdf_pkg::REG_DAY_OFFSET;
  logic [nrdf_pkg::CFG_W-1:0] cfg_data = '0;

  nmea_rmc_date_rollover_fix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_line_end(out_line_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } out_char_t;

  class rmc_scoreboard;
    logic [nrdf_pkg::OFFSET_BITS-1:0] offset;
    bit en;
    nrdf_pkg::phase_t ph;
    int unsigned ppos, fld, cif, cks;
    int unsigned digs[6];
    out_char_t pending[$];
    int errors;

    function void reset();
      offset = nrdf_pkg::OFFSET_RESET;
      en = 1;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      ph = nrdf_pkg::PH_START;
      ppos = 0;
      fld = 0;
      cif = 0;
      cks = 0;
    endfunction

    function bit leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function void push(int unsigned b, bit e = 0);
      out_char_t c;
      c.ch = b[7:0];
      c.eol = e;
      pending.push_back(c);
    endfunction

    function void push_x(int unsigned b);
      cks = (cks ^ b) & 8'hFF;
      push(b);
    endfunction

    function int unsigned dig(int unsigned i);
      return (i < cif && i < 6) ? digs[i] : 0;
    endfunction

    function void shift_date();
      int unsigned d, m, yy, yr, t, wd, mo, ln, bm;
      d = dig(0) * 10 + dig(1);
      m = dig(2) * 10 + dig(3);
      yy = dig(4) * 10 + dig(5);
      yr = (yy == 99) ? 1999 : 2000 + yy;
      t = d;
      if (m >= 1 && m <= 12) begin
        bm = 0;
        for (int j = 1; j < m; j++) bm += (j == 2) ? 28 : (j == 4 || j == 6 || j == 9 ||
                                            j == 11) ? 30 : 31;
        t += bm;
      end
      if (leap(yr) && m > 2) t += 1;
      wd = t + offset;
      while (wd > (leap(yr) ? 366 : 365)) begin
        wd -= leap(yr) ? 366 : 365;
        yr++;
      end
      mo = 1;
      while (mo < 12) begin
        ln = (mo == 2) ? (leap(yr) ? 29 : 28) : (mo == 4 || mo == 6 || mo == 9 ||
                                                 mo == 11) ? 30 : 31;
        if (wd <= ln) break;
        wd -= ln;
        mo++;
      end
      yy = yr % 100;
      push_x("0" + (wd / 10) % 10);
      push_x("0" + wd % 10);
      push_x("0" + mo / 10);
      push_x("0" + mo % 10);
      push_x("0" + yy / 10);
      push_x("0" + yy % 10);
    endfunction

    function int unsigned hexc(int unsigned v);
      v &= 15;
      return v < 10 ? "0" + v : "A" + v - 10;
    endfunction

    function void note_request(logic [7:0] b);
      string lead;
      lead = "$GPRMC";
      if (ph == nrdf_pkg::PH_START) begin
        if (en && b == lead[ppos]) begin
          if (ppos == 5) begin
            push("$");
            cks = 0;
            for (int i = 1; i < 6; i++) push_x(lead[i]);
            ph = nrdf_pkg::PH_RMC;
            ppos = 0;
            fld = 0;
            cif = 0;
          end else ppos++;
        end else begin
          for (int i = 0; i < ppos; i++) push(lead[i]);
          push(b, b == nrdf_pkg::CH_NL);
          ppos = 0;
          ph = (b == nrdf_pkg::CH_NL) ? nrdf_pkg::PH_START : nrdf_pkg::PH_PASS;
        end
        return;
      end
      if (ph == nrdf_pkg::PH_PASS) begin
        push(b, b == nrdf_pkg::CH_NL);
        if (b == nrdf_pkg::CH_NL) clear_line();
        return;
      end
      if (b == nrdf_pkg::CH_NL) begin
        push("*");
        push(hexc(cks >> 4));
        push(hexc(cks));
        push(nrdf_pkg::CH_NL, 1);
        clear_line();
        return;
      end
      if (ph == nrdf_pkg::PH_TAIL || b == nrdf_pkg::CH_CR) return;
      if (b == nrdf_pkg::CH_STAR || b == nrdf_pkg::CH_COMMA) begin
        if (fld == 9 && cif >= 1 && cif <= 5) shift_date();
        if (b == nrdf_pkg::CH_STAR) begin
          ph = nrdf_pkg::PH_TAIL;
          return;
        end
        if (fld <= 11) push_x(nrdf_pkg::CH_COMMA);
        if (fld <= 12) fld++;
        cif = 0;
        return;
      end
      if (fld <= 8) push_x(b);
      else if (fld == 9) begin
        if (cif < 6) begin
          digs[cif] = (b >= "0" && b <= "9") ? b - "0" : 0;
          cif++;
          if (cif == 6) shift_date();
        end
      end else if (fld == 12 && cif == 0) begin
        push_x(b);
        cif = 1;
      end
    endfunction

    function void check_char(logic [7:0] b, logic e);
      out_char_t x;
      if (pending.size() == 0) begin
        $error("unexpected output byte %h", b);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x.ch !== b) begin
        $error("out_byte expected %h actual %h", x.ch, b);
        errors++;
      end
      if (x.eol !== e) begin
        $error("out_line_end expected %b actual %b", x.eol, e);
        errors++;
      end
    endfunction
  endclass

  rmc_scoreboard sb;
  logic [7:0] stim[$];
  int cycles = 0;
  bit hold_rx = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("nmea_rmc_date_rollover_fix verification failed");
      $finish;
    end
  end

  always @(posedge clk) if (rst_n && out_valid && out_ready) sb.check_char(out_byte, out_line_end);

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, bit fast);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    sb.note_request(b);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[nrdf_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == nrdf_pkg::REG_DAY_OFFSET) sb.offset = v[nrdf_pkg::CFG_W-1:0];
    else sb.en = v[0];
    @(posedge clk);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) stim.push_back(s[i]);
  endtask

  task automatic add_rmc();
    int nf, dl;
    add_str("$GPRMC");
    nf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 13;
    for (int f = 0; f < nf; f++) begin
      stim.push_back(nrdf_pkg::CH_COMMA);
      if (f == 8) begin
        dl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 6;
        for (int j = 0; j < dl; j++)
          stim.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'("0" +
                         $urandom_range(0, 9)));
      end else
        for (int j = $urandom_range(0, 2); j > 0; j--)
          stim.push_back(8'("A" + $urandom_range(0, 25)));
    end
    if ($urandom_range(0, 1)) add_str("*5A");
    if ($urandom_range(0, 1)) stim.push_back(nrdf_pkg::CH_CR);
    stim.push_back(nrdf_pkg::CH_NL);
  endtask

  task automatic run_stim(bit fast);
    while (stim.size() != 0) send_byte(stim.pop_front(), fast);
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_str("$GPRMC,1,A,,,,,,,311299,x,y,Abc,q,r\n");
    add_str("$GPRMC,,,,,,,,,,,,\n$GPRMC,,,,,,,,,0\n$GPR\n$GPX\n");
    stim.push_back(8'hFF);
    stim.push_back(8'h00);
    stim.push_back(nrdf_pkg::CH_NL);
    run_stim(0);
    drain();
    write_reg(nrdf_pkg::REG_DAY_OFFSET, 0);
    add_str("$GPRMC,,,,,,,,,000099*12\r\n$GPRMC,,,,,,,,,3113x,,\n");
    run_stim(0);
    drain();
    write_reg(nrdf_pkg::REG_DAY_OFFSET, 16383);
    add_str("$GPRMC,,,,,,,,,290298,,,\n$GPRMC,a\n");
    run_stim(0);
    drain();
    write_reg(nrdf_pkg::REG_ENABLE, 0);
    add_str("$GPRMC,,,,,,,,,010120,,,\n");
    run_stim(0);
    drain();
    write_reg(nrdf_pkg::REG_ENABLE, 1);
    write_reg(nrdf_pkg::REG_DAY_OFFSET, 7168);
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(nrdf_pkg::REG_DAY_OFFSET, (ph == 3) ? 16383 : $urandom_range(0, 2000));
        write_reg(nrdf_pkg::REG_ENABLE, (ph == 2) ? 0 : 1);
      end
      if (ph == 1) add_rmc();
      else begin
        case ($urandom_range(0, 4))
          0: begin
            for (int j = $urandom_range(1, 8); j > 0; j--) stim.push_back(8'($urandom));
            stim.push_back(nrdf_pkg::CH_NL);
          end
          1: add_str("$GPGGA,1,2\n");
          default: add_rmc();
        endcase
      end
      if (ph == 1) hold_rx = 1;
      run_stim(ph == 1);
    end
    drain();
    if (sb.errors == 0) $display("nmea_rmc_date_rollover_fix verification clean");
    else $display("nmea_rmc_date_rollover_fix verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/nrdf_pkg.sv
rtl/nrdf_dp.sv
rtl/nrdf_ctrl.sv
rtl/nmea_rmc_date_rollover_fix.sv
bench/tb.sv
